[rtl/sha_pkg.sv]
// Shared types and constants for the slot handle allocator.
package sha_pkg;

    // Table size and owner identity width.
    localparam int SLOTS      = 1024;
    localparam int OWNER_BITS = 32;

    // Port widths, fixed by the request and response formats.
    localparam int FUNC_W      = 2;
    localparam int OWNER_ID_W  = 32;
    localparam int SLOT_PORT_W = 10;
    localparam int SERIAL_W    = 31;
    localparam int STATUS_W    = 2;
    localparam int CFG_W       = 11;

    // Widths derived from the table size and the entry fields.
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int TBL_W  = OWNER_BITS + SERIAL_W;

    localparam int MAX_SLOTS_RST = 1024;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ALLOC    = 2'd0,
        FUNC_FREE     = 2'd1,
        FUNC_VALIDATE = 2'd2,
        FUNC_SERIAL   = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK   = 2'd0,
        STAT_FULL = 2'd1,
        STAT_BAD  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } state_t;

    // One entry of the slot table.
    typedef struct packed {
        logic [OWNER_BITS-1:0] owner;
        logic [SERIAL_W-1:0]   serial;
    } entry_t;

endpackage

[rtl/slot_handle_allocator.sv]
// Top level of the slot handle allocator: request sequencer, slot table and free stack.
//
//  Channel | Handshake                 | Payload
//  --------+---------------------------+-------------------------------------
//  req     | req_valid / req_stall     | func, owner_id, slot
//  rsp     | rsp_valid / rsp_stall     | slot_out, serial, is_valid, status
//  cfg     | cfg_valid / cfg_ready     | cfg_data (max_slots)
//
// A request is taken in the accept cycle, which issues the reads of the slot
// table and the free stack; the execute state then computes the result, writes
// back and loads the response register. Each RAM has a single read port, and
// req_stall stays high until the block is back in idle, so no new request is taken before the last one is done.
// After reset the slot table is swept to zero, one entry a cycle, over all 1024 entries;
// req_stall stays high during the sweep, while configuration writes are taken.
// A request may be accepted while the previous response still waits; the block
// then holds in its execute cycle until the response register is free.
module slot_handle_allocator (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  logic [sha_pkg::FUNC_W-1:0]      func,
    input  logic [sha_pkg::OWNER_ID_W-1:0]  owner_id,
    input  logic [sha_pkg::SLOT_PORT_W-1:0] slot,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output logic [sha_pkg::SLOT_PORT_W-1:0] slot_out,
    output logic [sha_pkg::SERIAL_W-1:0]    serial,
    output logic                            is_valid,
    output logic [sha_pkg::STATUS_W-1:0]    status,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sha_pkg::CFG_W-1:0]       cfg_data
);

    import sha_pkg::*;

    localparam logic [SERIAL_W-1:0] SERIAL_MAX = '1;

    // Sequencer state.
    state_t              state_reg, state_next;
    logic [SLOT_W-1:0]   clr_idx_reg, clr_idx_next;

    // Captured request.
    func_t                  func_reg;
    logic [OWNER_BITS-1:0]  owner_reg;
    logic [SLOT_PORT_W-1:0] slot_reg;

    // Allocator bookkeeping.
    logic [CNT_W-1:0]    free_count_reg, free_count_next;
    logic [CNT_W-1:0]    high_water_reg, high_water_next;
    logic [SERIAL_W-1:0] serial_ctr_reg, serial_ctr_next;
    logic [CFG_W-1:0]    max_slots_reg;

    // Response register.
    logic                   rsp_valid_reg;
    logic [SLOT_PORT_W-1:0] slot_out_reg;
    logic [SERIAL_W-1:0]    serial_reg;
    logic                   is_valid_reg;
    status_t                status_reg;

    // RAM ports.
    logic              tbl_we;
    logic [SLOT_W-1:0] tbl_waddr;
    entry_t            tbl_wdata;
    entry_t            tbl_rdata;
    logic [TBL_W-1:0]  tbl_rdata_raw;
    logic              stk_we;
    logic [SLOT_W-1:0] stk_waddr;
    logic [SLOT_W-1:0] stk_wdata;
    logic [SLOT_W-1:0] stk_rdata;

    // Datapath helpers.
    logic                   req_fire;
    logic                   out_free;
    logic [CNT_W-1:0]       limit;
    logic                   in_range;
    logic                   owner_hit;
    logic                   owner_null;
    logic [SERIAL_W-1:0]    serial_inc;
    logic                   res_load;
    logic [SLOT_PORT_W-1:0] res_slot;
    logic [SERIAL_W-1:0]    res_serial;
    logic                   res_valid;
    status_t                res_status;

    assign req_stall = (state_reg != S_IDLE);
    assign req_fire  = req_valid && !req_stall;
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign cfg_ready = 1'b1;

    // The slot limit is the configured count saturated to the table size.
    assign limit = (int'(max_slots_reg) > SLOTS) ? CNT_W'(SLOTS) : CNT_W'(max_slots_reg);
    assign in_range   = int'(slot_reg) < int'(limit);
    assign tbl_rdata  = entry_t'(tbl_rdata_raw);
    assign owner_null = (owner_reg == '0);
    assign owner_hit  = (tbl_rdata.owner == owner_reg);
    assign serial_inc = (serial_ctr_reg == SERIAL_MAX) ? SERIAL_W'(1)
                                                       : serial_ctr_reg + SERIAL_W'(1);

    // Slot table: owner and serial of every slot, in one word.
    sha_ram #(
        .WIDTH (TBL_W),
        .DEPTH (SLOTS)
    ) u_tbl_ram (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .re    (req_fire),
        .raddr (SLOT_W'(slot)),
        .rdata (tbl_rdata_raw)
    );

    // Free stack: the top entry sits at free_count - 1 and is read on every
    // accept, so a pop has its index ready in the execute cycle.
    sha_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SLOTS)
    ) u_stk_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (req_fire),
        .raddr (SLOT_W'(free_count_reg - CNT_W'(1))),
        .rdata (stk_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_idx_reg    <= '0;
            free_count_reg <= '0;
            high_water_reg <= '0;
            serial_ctr_reg <= '0;
            max_slots_reg  <= CFG_W'(MAX_SLOTS_RST);
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_idx_reg    <= clr_idx_next;
            free_count_reg <= free_count_next;
            high_water_reg <= high_water_next;
            serial_ctr_reg <= serial_ctr_next;
            if (cfg_valid && cfg_ready)
            begin
                max_slots_reg <= cfg_data;
            end
            if (res_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Request capture and response payload need no reset.
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            func_reg  <= func_t'(func);
            owner_reg <= OWNER_BITS'(owner_id);
            slot_reg  <= slot;
        end
        if (res_load)
        begin
            slot_out_reg <= res_slot;
            serial_reg   <= res_serial;
            is_valid_reg <= res_valid;
            status_reg   <= res_status;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_idx_next    = clr_idx_reg;
        free_count_next = free_count_reg;
        high_water_next = high_water_reg;
        serial_ctr_next = serial_ctr_reg;
        tbl_we          = 1'b0;
        tbl_waddr       = SLOT_W'(slot_reg);
        tbl_wdata       = '0;
        stk_we          = 1'b0;
        stk_waddr       = SLOT_W'(free_count_reg);
        stk_wdata       = SLOT_W'(slot_reg);
        res_load        = 1'b0;
        res_slot        = slot_reg;
        res_serial      = '0;
        res_valid       = 1'b0;
        res_status      = STAT_OK;

        case (state_reg)
            S_CLEAR:
            begin
                tbl_we       = 1'b1;
                tbl_waddr    = clr_idx_reg;
                clr_idx_next = clr_idx_reg + SLOT_W'(1);
                if (clr_idx_reg == SLOT_W'(SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                if (out_free)
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                    case (func_reg)
                        FUNC_ALLOC:
                        begin
                            // A slot handed out always has serial zero, since
                            // free clears it and unused slots were never set.
                            res_slot        = '0;
                            tbl_wdata.owner = owner_reg;
                            if (owner_null)
                            begin
                                res_status = STAT_BAD;
                            end
                            else if (free_count_reg != '0)
                            begin
                                free_count_next = free_count_reg - CNT_W'(1);
                                tbl_we          = 1'b1;
                                tbl_waddr       = stk_rdata;
                                res_slot        = SLOT_PORT_W'(stk_rdata);
                            end
                            else if (high_water_reg < limit)
                            begin
                                high_water_next = high_water_reg + CNT_W'(1);
                                tbl_we          = 1'b1;
                                tbl_waddr       = SLOT_W'(high_water_reg);
                                res_slot        = SLOT_PORT_W'(high_water_reg);
                            end
                            else
                            begin
                                res_status = STAT_FULL;
                            end
                        end

                        FUNC_FREE:
                        begin
                            if (owner_null || !in_range || !owner_hit)
                            begin
                                res_status = STAT_BAD;
                            end
                            else
                            begin
                                tbl_we = 1'b1;
                                // A push onto a full stack is dropped.
                                if (int'(free_count_reg) < SLOTS)
                                begin
                                    stk_we          = 1'b1;
                                    free_count_next = free_count_reg + CNT_W'(1);
                                end
                            end
                        end

                        FUNC_VALIDATE:
                        begin
                            if (!in_range)
                            begin
                                res_status = STAT_BAD;
                            end
                            else
                            begin
                                res_valid = !owner_null && owner_hit;
                            end
                        end

                        FUNC_SERIAL:
                        begin
                            if (!in_range || (tbl_rdata.owner == '0))
                            begin
                                res_status = STAT_BAD;
                            end
                            else if (tbl_rdata.serial == '0)
                            begin
                                // First request draws the next counter value.
                                serial_ctr_next  = serial_inc;
                                tbl_we           = 1'b1;
                                tbl_wdata.owner  = tbl_rdata.owner;
                                tbl_wdata.serial = serial_inc;
                                res_serial       = serial_inc;
                            end
                            else
                            begin
                                res_serial = tbl_rdata.serial;
                            end
                        end

                        default:
                        begin
                            res_status = STAT_BAD;
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign slot_out  = slot_out_reg;
    assign serial    = serial_reg;
    assign is_valid  = is_valid_reg;
    assign status    = status_reg;

endmodule

[rtl/sha_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module sha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/sha_checker.sv]
// Port-level checks for the slot handle allocator, bound to its top level.
module sha_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            req_valid,
    input logic                            req_stall,
    input logic                            rsp_valid,
    input logic                            rsp_stall,
    input logic [sha_pkg::SLOT_PORT_W-1:0] slot_out,
    input logic [sha_pkg::SERIAL_W-1:0]    serial,
    input logic                            is_valid,
    input logic [sha_pkg::STATUS_W-1:0]    status
);

    import sha_pkg::*;

    // A response held back by the consumer stays put.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(slot_out) && $stable(serial)
                                   && $stable(is_valid) && $stable(status))
        else $error("response changed while stalled");

    // An accepted request is never followed by another accepted in the next cycle.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request accepted in back-to-back cycles");

    // A failed request carries neither a serial nor a positive validate.
    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status != STAT_OK) |-> (serial == '0) && !is_valid)
        else $error("failed response carries a serial or a valid flag");

    // A full table grants no slot.
    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == STAT_FULL) |-> (slot_out == '0))
        else $error("full response grants a slot");

    // A positive validate never comes with a serial.
    a_valid_no_serial: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && is_valid |-> (serial == '0) && (status == STAT_OK))
        else $error("validate response carries a serial or an error");

endmodule

bind slot_handle_allocator sha_checker u_sha_checker (.*);
